>>> rtl/access_point_baseline_checker_macros.svh
// Assertion macros shared by the access point baseline checker modules.
`ifndef ACCESS_POINT_BASELINE_CHECKER_MACROS_SVH
`define ACCESS_POINT_BASELINE_CHECKER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define APBC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define APBC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define APBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/apbc_pkg.sv
// Shared types, constants and helper functions of the access point baseline checker.
package apbc_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Name and field widths.
    localparam int NAME_BYTES = 32;
    localparam int NAME_BITS  = NAME_BYTES * 8;
    localparam int LEN_W      = 6;
    localparam int ADDR_W     = 48;
    localparam int CHAN_W     = 8;
    localparam int RES_IDX_W  = 4;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_BLANK     = 3'd0,
        ST_LEARNED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_MATCH     = 3'd3,
        ST_ADDR_WARN = 3'd4,
        ST_CHAN_INFO = 3'd5,
        ST_SEEDED    = 3'd6,
        ST_SEED_FULL = 3'd7
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CHECK,
        S_WRITE,
        S_RESULT
    } t_state;

    // One row of the name memory.
    typedef struct packed {
        logic [LEN_W-1:0]     len;
        logic [NAME_BITS-1:0] name;
    } t_name_row;

    // One row of the attribute memory.
    typedef struct packed {
        logic [ADDR_W-1:0] bssid;
        logic [CHAN_W-1:0] chan;
    } t_attr_row;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    capture;
        logic    scan_start;
        logic    scan_step;
        logic    check;
        logic    write_new;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seed;
        logic blank;
        logic full;
        logic empty;
        logic hit;
        logic miss;
        logic out_free;
    } t_dp_stat;

    // Lengths beyond the longest name count as the longest name.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : len;
    endfunction

    // Clear every name byte at or beyond the name length.
    function automatic logic [NAME_BITS-1:0] mask_name(input logic [NAME_BITS-1:0] raw,
                                                       input logic [LEN_W-1:0]     len);
        logic [NAME_BITS-1:0] v;
        v = raw;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (LEN_W'(b) >= len) begin
                v[b*8 +: 8] = 8'h00;
            end
        end
        return v;
    endfunction

endpackage

>>> rtl/apbc_in_if.sv
// Input channel of the access point baseline checker: one scan result or seed entry.
interface apbc_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] ssid_word0;
    logic [63:0] ssid_word1;
    logic [63:0] ssid_word2;
    logic [63:0] ssid_word3;
    logic [5:0]  ssid_length;
    logic [47:0] bssid;
    logic [7:0]  channel;

    modport source (
        output valid, operation, ssid_word0, ssid_word1, ssid_word2, ssid_word3,
               ssid_length, bssid, channel,
        input  ready
    );

    modport sink (
        input  valid, operation, ssid_word0, ssid_word1, ssid_word2, ssid_word3,
               ssid_length, bssid, channel,
        output ready
    );
endinterface

>>> rtl/apbc_out_if.sv
// Output channel of the access point baseline checker: one result per input transfer.
interface apbc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [47:0] baseline_bssid;
    logic [7:0]  previous_channel;

    modport source (
        output valid, status, entry_index, baseline_bssid, previous_channel,
        input  ready
    );

    modport sink (
        input  valid, status, entry_index, baseline_bssid, previous_channel,
        output ready
    );
endinterface

>>> rtl/apbc_ctrl.sv
// Controller state machine of the access point baseline checker.
`include "access_point_baseline_checker_macros.svh"

module apbc_ctrl
    import apbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_cmd          = '0;
        n_cmd.status   = ST_BLANK;
        case (r_state)
            S_IDLE: begin
                n_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.seed) begin
                    if (i_stat.full) begin
                        n_cmd.set_status = 1'b1;
                        n_cmd.status     = ST_SEED_FULL;
                        n_state          = S_RESULT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else if (i_stat.blank) begin
                    n_cmd.set_status = 1'b1;
                    n_cmd.status     = ST_BLANK;
                    n_state          = S_RESULT;
                end else if (i_stat.empty) begin
                    n_state = S_WRITE;
                end else begin
                    n_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_CHECK;
                end else if (i_stat.miss) begin
                    if (i_stat.full) begin
                        n_cmd.set_status = 1'b1;
                        n_cmd.status     = ST_FULL;
                        n_state          = S_RESULT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_CHECK: begin
                n_cmd.check = 1'b1;
                n_state     = S_RESULT;
            end
            S_WRITE: begin
                n_cmd.write_new = 1'b1;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = n_cmd;

    // A full table is never written, and a transfer always starts decoding.
    `APBC_ASSERT_IMPL(a_no_write_when_full, n_cmd.write_new, !i_stat.full, "write into full table")
    `APBC_ASSERT_NEXT(a_capture_decodes, n_cmd.capture, r_state == S_DECODE, "capture lost")

endmodule

>>> rtl/apbc_dp.sv
// Datapath of the access point baseline checker: input latch, table memories, scan and result.
`include "access_point_baseline_checker_macros.svh"

module apbc_dp
    import apbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_operation,
    input  logic [NAME_BITS-1:0] i_name_raw,
    input  logic [LEN_W-1:0]     i_ssid_length,
    input  logic [ADDR_W-1:0]    i_bssid,
    input  logic [CHAN_W-1:0]    i_channel,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_status              o_status,
    output logic [RES_IDX_W-1:0] o_entry_index,
    output logic [ADDR_W-1:0]    o_baseline_bssid,
    output logic [CHAN_W-1:0]    o_previous_channel
);

    // Table memories.
    t_name_row name_mem [TABLE_ENTRIES];
    t_attr_row attr_mem [TABLE_ENTRIES];

    // Latched item.
    logic                 r_op;
    logic [NAME_BITS-1:0] r_name;
    logic [LEN_W-1:0]     r_len;
    logic [ADDR_W-1:0]    r_addr;
    logic [CHAN_W-1:0]    r_chan;

    // Table fill and scan state.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_scan_idx;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    t_name_row        r_rd_row;
    logic [IDX_W-1:0] r_hit_idx;
    t_attr_row        r_attr_rd;

    // Result and output registers.
    t_status              r_res_status;
    logic [RES_IDX_W-1:0] r_res_index;
    logic [ADDR_W-1:0]    r_res_bssid;
    logic [CHAN_W-1:0]    r_res_chan;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [RES_IDX_W-1:0] r_out_index;
    logic [ADDR_W-1:0]    r_out_bssid;
    logic [CHAN_W-1:0]    r_out_chan;

    logic [LEN_W-1:0] in_len;
    logic             scan_issue;
    logic             hit;
    logic             miss;
    logic             addr_diff;
    logic             chan_diff;

    // Latch the item with its name masked to its clamped length.
    assign in_len = clamp_len(i_ssid_length);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_len  <= in_len;
            r_name <= mask_name(i_name_raw, in_len);
            r_addr <= i_bssid;
            r_chan <= i_channel;
        end
    end

    // Scan compare: one stored row per cycle against the latched name.
    assign scan_issue = i_cmd.scan_step && (r_scan_idx < r_count);
    assign hit        = r_rd_vld && (r_rd_row.len == r_len) && (r_rd_row.name == r_name);
    assign miss       = r_rd_vld && !hit && ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count);

    // Entry count and scan pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cmd.write_new) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_rd_vld   <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
            end
        end
    end

    // Name memory: one write port for new entries, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_new) begin
            name_mem[r_count[IDX_W-1:0]] <= '{len: r_len, name: r_name};
        end
        if (scan_issue) begin
            r_rd_row <= name_mem[r_scan_idx[IDX_W-1:0]];
            r_rd_idx <= r_scan_idx[IDX_W-1:0];
        end
    end

    // Attribute memory: written for new entries and channel updates, read on a hit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_new) begin
            attr_mem[r_count[IDX_W-1:0]] <= '{bssid: r_addr, chan: r_chan};
        end else if (i_cmd.check && !addr_diff && chan_diff) begin
            attr_mem[r_hit_idx].chan <= r_chan;
        end
        if (i_cmd.scan_step && hit) begin
            r_attr_rd <= attr_mem[r_rd_idx];
            r_hit_idx <= r_rd_idx;
        end
    end

    // Compare a known entry with the observation.
    assign addr_diff = (r_attr_rd.bssid != r_addr);
    assign chan_diff = (r_attr_rd.chan != r_chan);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
            r_res_index  <= '0;
            r_res_bssid  <= '0;
            r_res_chan   <= '0;
        end else if (i_cmd.write_new) begin
            r_res_status <= r_op ? ST_SEEDED : ST_LEARNED;
            r_res_index  <= RES_IDX_W'(r_count);
            r_res_bssid  <= '0;
            r_res_chan   <= '0;
        end else if (i_cmd.check) begin
            if (addr_diff) begin
                r_res_status <= ST_ADDR_WARN;
            end else if (chan_diff) begin
                r_res_status <= ST_CHAN_INFO;
            end else begin
                r_res_status <= ST_MATCH;
            end
            r_res_index <= RES_IDX_W'(r_hit_idx);
            r_res_bssid <= r_attr_rd.bssid;
            r_res_chan  <= r_attr_rd.chan;
        end
    end

    // Output register: holds a result until the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_bssid  <= r_res_bssid;
            r_out_chan   <= r_res_chan;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_entry_index      = r_out_index;
    assign o_baseline_bssid   = r_out_bssid;
    assign o_previous_channel = r_out_chan;

    // Status towards the controller.
    always_comb begin
        o_stat.seed     = r_op;
        o_stat.blank    = (r_len == '0);
        o_stat.full     = (r_count == CNT_W'(TABLE_ENTRIES));
        o_stat.empty    = (r_count == '0);
        o_stat.hit      = hit;
        o_stat.miss     = miss;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // The table never overfills, grows by one per write, and a loaded result is offered.
    `APBC_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(TABLE_ENTRIES), "entry count overflow")
    `APBC_ASSERT_NEXT(a_count_step, i_cmd.write_new, r_count == $past(r_count) + CNT_W'(1), "count step")
    `APBC_ASSERT_NEXT(a_load_offers, i_cmd.load_out, r_out_valid, "loaded result not offered")

endmodule

>>> rtl/access_point_baseline_checker.sv
// Top level of the access point baseline checker.
//
// The block keeps a table of trusted networks, each a name, a station address and a channel.
// Input transfers on i_in carry either a seed entry (operation 1), appended without a search,
// or a scan observation (operation 0), looked up by name in the table and then learned or
// checked against the stored address and channel. Every input transfer gives exactly one
// result transfer on o_out, in input order.
// A scan with a blank name, or a seed on a full table, goes from decode straight to the result;
// a stored seed passes through the write state. Names not in the table, or found in the last
// entry, take longest: the walk over the name memory, which reads one stored row per cycle,
// sets the length. One item is processed at a time; a new item is accepted in the cycle after
// its result is loaded.
// Results sit in an output register, so the next input is taken while a result still waits.
// If the receiver stalls, the finished result of the following item waits in the block and
// input is held off until the output register frees.
// Synchronous reset empties the table (the entry count goes to zero) and drops any pending
// result; no input is taken while reset is held. Stored entries need no clearing since only
// written entries are read.
module access_point_baseline_checker
    import apbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    apbc_in_if.sink      i_in,
    apbc_out_if.source   o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_status  w_status;

    // Sequencing of each item.
    apbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Table storage, lookup and result.
    apbc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_operation        (i_in.operation),
        .i_name_raw         ({i_in.ssid_word3, i_in.ssid_word2,
                              i_in.ssid_word1, i_in.ssid_word0}),
        .i_ssid_length      (i_in.ssid_length),
        .i_bssid            (i_in.bssid),
        .i_channel          (i_in.channel),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_status           (w_status),
        .o_entry_index      (o_out.entry_index),
        .o_baseline_bssid   (o_out.baseline_bssid),
        .o_previous_channel (o_out.previous_channel)
    );

    // Handshake and status code onto the channels; input is refused during reset.
    assign i_in.ready   = w_cmd.in_ready && i_rst_n;
    assign o_out.status = w_status;

endmodule
